/* design/png_stored_stream_encoder_core_assert.svh */
// Assertion macros for the PNG stored-stream encoder core.
// Depends on nothing; taken in by the back part, which checks its own logic.
`ifndef PNG_STORED_STREAM_ENCODER_CORE_ASSERT_SVH
`define PNG_STORED_STREAM_ENCODER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define PNGSE_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pngse assertion failed");
`define PNGSE_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("pngse assertion failed");
`else
`define PNGSE_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define PNGSE_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

/* design/pngse_pkg.sv */
// Shared types, constants and CRC helper for the PNG stored-stream encoder.
// Depends on nothing.
package pngse_pkg;

    localparam int SIDE_W = 15;
    localparam int RAW_W = 30;
    localparam int BB_W = 16;
    localparam int CFG_W = 14;
    localparam int QDEPTH = 4;
    localparam int DEF_BLOCK_BYTES = 65535;
    localparam int DEF_MAX_SIDE = 8192;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [16:0] ADLER_MOD = 17'd65521;
    localparam logic [31:0] TAG_IHDR = 32'h49484452;
    localparam logic [31:0] TAG_IDAT = 32'h49444154;
    localparam logic [31:0] TAG_IEND = 32'h49454E44;

    typedef enum logic {
        OP_START = 1'b0,
        OP_PIXEL = 1'b1
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [SIDE_W-1:0] width;
        logic [SIDE_W-1:0] height;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic              first_col;
        logic              last_pix;
    } item_t;

    typedef struct packed {
        logic             done;
        logic [RAW_W-1:0] raw;
        logic [31:0]      zlen;
    } zl_res_t;

    function automatic logic [31:0] crc8(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* design/pngse_front.sv */
// Front part: accepts input transactions, tracks the frame position and
// classifies items for the queue. Depends on pngse_pkg.
module pngse_front #(
    parameter int MAX_SIDE = pngse_pkg::DEF_MAX_SIDE
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [23:0]                   s_tdata,  // red, green, blue
    input  logic                          s_tuser,  // operation
    input  logic [pngse_pkg::CFG_W-1:0]   cfg_width,
    input  logic [pngse_pkg::CFG_W-1:0]   cfg_height,
    input  logic                          q_full,
    output logic                          q_push,
    output pngse_pkg::item_t              q_item
);
    import pngse_pkg::*;

    localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(MAX_SIDE);

    logic              active_reg;
    logic [SIDE_W-1:0] col_reg;
    logic [SIDE_W-1:0] row_reg;
    logic [SIDE_W-1:0] latw_reg;
    logic [SIDE_W-1:0] lath_reg;
    logic              accept;
    logic              is_start;
    logic              col_wrap;
    logic              row_wrap;
    logic [SIDE_W-1:0] col_inc;
    logic [SIDE_W-1:0] row_inc;

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
        logic [SIDE_W-1:0] ext;
        ext = SIDE_W'(v);
        if (ext == '0) return SIDE_W'(1);
        if (ext > SIDE_MAX) return SIDE_MAX;
        return ext;
    endfunction

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign is_start = (op_t'(s_tuser) == OP_START);
    assign col_inc  = col_reg + SIDE_W'(1);
    assign row_inc  = row_reg + SIDE_W'(1);
    assign col_wrap = (col_inc >= latw_reg);
    assign row_wrap = (row_inc >= lath_reg);
    assign q_push   = accept && (is_start || active_reg);

    always_comb begin
        q_item.op        = op_t'(s_tuser);
        q_item.width     = clamp_side(cfg_width);
        q_item.height    = clamp_side(cfg_height);
        q_item.red       = s_tdata[7:0];
        q_item.green     = s_tdata[15:8];
        q_item.blue      = s_tdata[23:16];
        q_item.first_col = (col_reg == '0);
        q_item.last_pix  = col_wrap && row_wrap;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            col_reg    <= '0;
            row_reg    <= '0;
            latw_reg   <= SIDE_W'(1);
            lath_reg   <= SIDE_W'(1);
        end else if (accept) begin
            if (is_start) begin
                active_reg <= 1'b1;
                col_reg    <= '0;
                row_reg    <= '0;
                latw_reg   <= clamp_side(cfg_width);
                lath_reg   <= clamp_side(cfg_height);
            end else if (active_reg) begin
                if (col_wrap) begin
                    col_reg <= '0;
                    if (row_wrap) begin
                        row_reg    <= '0;
                        active_reg <= 1'b0;
                    end else begin
                        row_reg <= row_inc;
                    end
                end else begin
                    col_reg <= col_inc;
                end
            end
        end
    end

endmodule

/* design/pngse_queue.sv */
// Short queue of classified items between the front and back parts.
// Depends on pngse_pkg.
module pngse_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  pngse_pkg::item_t push_item,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output pngse_pkg::item_t head
);
    import pngse_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    item_t            slot_reg [QDEPTH];
    logic [PTR_W-1:0] wr_reg;
    logic [PTR_W-1:0] rd_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full      = (cnt_reg == CNT_W'(QDEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = slot_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + PTR_W'(1);
            if (pop) rd_reg <= rd_reg + PTR_W'(1);
            if (push && !pop) cnt_reg <= cnt_reg + CNT_W'(1);
            else if (pop && !push) cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

endmodule

/* design/pngse_zlen.sv */
// Frame size unit: raw byte count by one multiply, stored block count by a
// reciprocal multiply, then the IDAT length. Depends on pngse_pkg.
module pngse_zlen #(
    parameter int BLOCK_BYTES = pngse_pkg::DEF_BLOCK_BYTES
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [pngse_pkg::SIDE_W-1:0] width,
    input  logic [pngse_pkg::SIDE_W-1:0] height,
    output pngse_pkg::zl_res_t           res
);
    import pngse_pkg::*;

    localparam int DIV_N  = RAW_W + 1;
    localparam int DIV_L  = $clog2(BLOCK_BYTES);
    localparam int DIV_S  = DIV_N + DIV_L;
    localparam int PROD_W = 2 * DIV_N + 1;
    localparam logic [63:0] DIV_M64 =
        ((64'd1 << DIV_S) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);
    localparam logic [DIV_N:0]   RECIP = DIV_M64[DIV_N:0];
    localparam logic [DIV_N-1:0] BB_M1 = DIV_N'(BLOCK_BYTES - 1);

    typedef enum logic [1:0] {Z_IDLE, Z_MUL, Z_DIV, Z_SUM} zstate_t;

    zstate_t           state_reg;
    logic              done_reg;
    logic [SIDE_W-1:0] w_reg;
    logic [SIDE_W-1:0] h_reg;
    logic [RAW_W-1:0]  raw_reg;
    logic [RAW_W-1:0]  quo_reg;
    logic [31:0]       zlen_reg;
    logic [SIDE_W+1:0] row_bytes;
    logic [DIV_N-1:0]  div_in;
    logic [PROD_W-1:0] prod;

    assign row_bytes = {2'b00, w_reg} + {1'b0, w_reg, 1'b0} + (SIDE_W + 2)'(1);
    assign div_in    = {1'b0, raw_reg} + BB_M1;
    assign prod      = PROD_W'(div_in) * PROD_W'(RECIP);

    assign res.done = done_reg;
    assign res.raw  = raw_reg;
    assign res.zlen = zlen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= Z_IDLE;
            done_reg  <= 1'b0;
        end else if (start) begin
            state_reg <= Z_MUL;
            done_reg  <= 1'b0;
            w_reg     <= width;
            h_reg     <= height;
        end else begin
            unique case (state_reg)
                Z_IDLE: ;
                Z_MUL: begin
                    raw_reg   <= RAW_W'(32'(h_reg) * 32'(row_bytes));
                    state_reg <= Z_DIV;
                end
                Z_DIV: begin
                    quo_reg   <= RAW_W'(prod >> DIV_S);
                    state_reg <= Z_SUM;
                end
                Z_SUM: begin
                    zlen_reg  <= 32'd6 + 32'(raw_reg) + {quo_reg, 2'b00} + 32'(quo_reg);
                    done_reg  <= 1'b1;
                    state_reg <= Z_IDLE;
                end
                default: state_reg <= Z_IDLE;
            endcase
        end
    end

endmodule

/* design/pngse_back.sv */
// Back part: sequences the PNG bytes of each queued item, keeps the chunk
// CRC-32, the Adler-32 and stored block fill, drives the result register.
// Depends on pngse_pkg and the assertion header.
`include "png_stored_stream_encoder_core_assert.svh"
module pngse_back #(
    parameter int BLOCK_BYTES = pngse_pkg::DEF_BLOCK_BYTES
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  pngse_pkg::item_t   q_item,
    output logic               q_pop,
    output logic               zl_start,
    input  pngse_pkg::zl_res_t zl_res,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,  // out_byte
    output logic               m_tlast,  // last_of_run
    output logic               m_tuser   // file_end
);
    import pngse_pkg::*;

    localparam logic [BB_W-1:0]  BB     = BB_W'(BLOCK_BYTES);
    localparam logic [RAW_W-1:0] BB_RAW = RAW_W'(BLOCK_BYTES);
    localparam logic [2:0]       HK_DONE = 3'd5;
    localparam logic [5:0]       ST_LAST = 6'd42;
    localparam logic [5:0]       TL_LAST = 6'd19;

    typedef enum logic [1:0] {B_IDLE, B_START, B_RAW, B_TAIL} state_t;

    state_t           state_reg;
    logic [5:0]       step_reg;
    logic [1:0]       ri_reg;
    logic [2:0]       hk_reg;
    item_t            cur_reg;
    logic [31:0]      crc_reg;
    logic [15:0]      alo_reg;
    logic [15:0]      ahi_reg;
    logic [BB_W-1:0]  fill_reg;
    logic [RAW_W-1:0] rem_reg;
    logic             out_valid_reg;
    logic [7:0]       out_data_reg;
    logic             out_last_reg;
    logic             out_end_reg;

    logic             out_free;
    logic             em_valid;
    logic [7:0]       em_byte;
    logic             em_crc;
    logic             em_tag;
    logic             em_last;
    logic             em_end;
    logic             em_raw;
    logic             em_hdr;
    logic             fire;
    logic             entry_done;
    logic             load;
    logic [5:0]       sub1;
    logic [BB_W-1:0]  blk_len;
    logic [BB_W-1:0]  blk_nlen;
    logic [7:0]       raw_byte;
    logic [31:0]      crc_base;
    logic [16:0]      lo_sum;
    logic [16:0]      lo_mod;
    logic [16:0]      hi_sum;
    logic [16:0]      hi_mod;
    logic [BB_W-1:0]  fill_inc;

    function automatic logic [7:0] be_byte(input logic [31:0] x, input logic [1:0] i);
        case (i)
            2'd0:    return x[31:24];
            2'd1:    return x[23:16];
            2'd2:    return x[15:8];
            default: return x[7:0];
        endcase
    endfunction

    function automatic logic [7:0] sig_byte(input logic [2:0] i);
        case (i)
            3'd0:    return 8'h89;
            3'd1:    return 8'h50;
            3'd2:    return 8'h4E;
            3'd3:    return 8'h47;
            3'd4:    return 8'h0D;
            3'd5:    return 8'h0A;
            3'd6:    return 8'h1A;
            default: return 8'h0A;
        endcase
    endfunction

    assign out_free = !out_valid_reg || m_tready;
    assign sub1     = step_reg - 6'd1;
    assign blk_len  = (rem_reg < BB_RAW) ? rem_reg[BB_W-1:0] : BB;
    assign blk_nlen = ~blk_len;

    always_comb begin
        case (ri_reg)
            2'd0:    raw_byte = 8'd0;
            2'd1:    raw_byte = cur_reg.red;
            2'd2:    raw_byte = cur_reg.green;
            default: raw_byte = cur_reg.blue;
        endcase
    end

    always_comb begin
        em_valid = 1'b0;
        em_byte  = 8'd0;
        em_crc   = 1'b0;
        em_tag   = 1'b0;
        em_last  = 1'b0;
        em_end   = 1'b0;
        em_raw   = 1'b0;
        em_hdr   = 1'b0;
        unique case (state_reg)
            B_IDLE: ;
            B_START: begin
                em_valid = 1'b1;
                case (step_reg) inside
                    [6'd0:6'd7]:   em_byte = sig_byte(step_reg[2:0]);
                    [6'd8:6'd11]:  em_byte = be_byte(32'd13, step_reg[1:0]);
                    [6'd12:6'd15]: begin
                        em_byte = be_byte(TAG_IHDR, step_reg[1:0]);
                        em_crc  = 1'b1;
                        em_tag  = (step_reg == 6'd12);
                    end
                    [6'd16:6'd19]: begin
                        em_byte = be_byte(32'(cur_reg.width), step_reg[1:0]);
                        em_crc  = 1'b1;
                    end
                    [6'd20:6'd23]: begin
                        em_byte = be_byte(32'(cur_reg.height), step_reg[1:0]);
                        em_crc  = 1'b1;
                    end
                    6'd24: begin
                        em_byte = 8'd8;
                        em_crc  = 1'b1;
                    end
                    6'd25: begin
                        em_byte = 8'd2;
                        em_crc  = 1'b1;
                    end
                    [6'd26:6'd28]: em_crc = 1'b1;
                    [6'd29:6'd32]: em_byte = be_byte(~crc_reg, sub1[1:0]);
                    [6'd33:6'd36]: begin
                        em_byte  = be_byte(zl_res.zlen, sub1[1:0]);
                        em_valid = zl_res.done;
                    end
                    [6'd37:6'd40]: begin
                        em_byte = be_byte(TAG_IDAT, sub1[1:0]);
                        em_crc  = 1'b1;
                        em_tag  = (step_reg == 6'd37);
                    end
                    6'd41: begin
                        em_byte = 8'h78;
                        em_crc  = 1'b1;
                    end
                    6'd42: begin
                        em_byte  = 8'h01;
                        em_crc   = 1'b1;
                        em_last  = 1'b1;
                        em_valid = zl_res.done;
                    end
                    default: em_valid = 1'b0;
                endcase
            end
            B_RAW: begin
                em_valid = 1'b1;
                em_crc   = 1'b1;
                if (fill_reg == '0 && hk_reg != HK_DONE) begin
                    em_hdr = 1'b1;
                    case (hk_reg)
                        3'd0:    em_byte = {7'd0, (rem_reg <= BB_RAW)};
                        3'd1:    em_byte = blk_len[7:0];
                        3'd2:    em_byte = blk_len[15:8];
                        3'd3:    em_byte = blk_nlen[7:0];
                        default: em_byte = blk_nlen[15:8];
                    endcase
                end else begin
                    em_raw  = 1'b1;
                    em_byte = raw_byte;
                    em_last = (ri_reg == 2'd3) && !cur_reg.last_pix;
                end
            end
            B_TAIL: begin
                em_valid = 1'b1;
                case (step_reg) inside
                    [6'd0:6'd3]: begin
                        em_byte = be_byte({ahi_reg, alo_reg}, step_reg[1:0]);
                        em_crc  = 1'b1;
                    end
                    [6'd4:6'd7]:   em_byte = be_byte(~crc_reg, step_reg[1:0]);
                    [6'd8:6'd11]:  em_byte = 8'd0;
                    [6'd12:6'd15]: begin
                        em_byte = be_byte(TAG_IEND, step_reg[1:0]);
                        em_crc  = 1'b1;
                        em_tag  = (step_reg == 6'd12);
                    end
                    [6'd16:6'd19]: begin
                        em_byte = be_byte(~crc_reg, step_reg[1:0]);
                        em_last = (step_reg == TL_LAST);
                        em_end  = (step_reg == TL_LAST);
                    end
                    default: em_valid = 1'b0;
                endcase
            end
            default: ;
        endcase
    end

    assign fire = em_valid && out_free;
    assign entry_done = fire && (
        (state_reg == B_START && step_reg == ST_LAST) ||
        (state_reg == B_TAIL && step_reg == TL_LAST) ||
        (state_reg == B_RAW && em_raw && ri_reg == 2'd3 && !cur_reg.last_pix));
    assign load     = q_valid && (state_reg == B_IDLE || entry_done);
    assign q_pop    = load;
    assign zl_start = load && (q_item.op == OP_START);

    assign crc_base = em_tag ? 32'hFFFFFFFF : crc_reg;
    assign lo_sum   = {1'b0, alo_reg} + {9'd0, em_byte};
    assign lo_mod   = (lo_sum >= ADLER_MOD) ? (lo_sum - ADLER_MOD) : lo_sum;
    assign hi_sum   = {1'b0, ahi_reg} + lo_mod;
    assign hi_mod   = (hi_sum >= ADLER_MOD) ? (hi_sum - ADLER_MOD) : hi_sum;
    assign fill_inc = fill_reg + BB_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            step_reg      <= '0;
            ri_reg        <= '0;
            hk_reg        <= '0;
            crc_reg       <= 32'hFFFFFFFF;
            alo_reg       <= 16'd1;
            ahi_reg       <= 16'd0;
            fill_reg      <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_free) out_valid_reg <= em_valid;
            if (fire) begin
                out_data_reg <= em_byte;
                out_last_reg <= em_last;
                out_end_reg  <= em_end;
                if (em_crc) crc_reg <= crc8(crc_base, em_byte);
                step_reg <= step_reg + 6'd1;
                if (em_hdr) hk_reg <= hk_reg + 3'd1;
                if (em_raw) begin
                    alo_reg  <= lo_mod[15:0];
                    ahi_reg  <= hi_mod[15:0];
                    fill_reg <= (fill_inc == BB) ? '0 : fill_inc;
                    if (rem_reg != '0) rem_reg <= rem_reg - RAW_W'(1);
                    ri_reg <= ri_reg + 2'd1;
                    hk_reg <= '0;
                    if (ri_reg == 2'd3 && cur_reg.last_pix) begin
                        state_reg <= B_TAIL;
                        step_reg  <= '0;
                    end
                end
                if (state_reg == B_START && step_reg == ST_LAST) begin
                    alo_reg  <= 16'd1;
                    ahi_reg  <= 16'd0;
                    fill_reg <= '0;
                    rem_reg  <= zl_res.raw;
                end
                if (state_reg == B_TAIL && step_reg == TL_LAST) begin
                    alo_reg  <= 16'd1;
                    ahi_reg  <= 16'd0;
                    fill_reg <= '0;
                    rem_reg  <= '0;
                end
                if (entry_done) state_reg <= B_IDLE;
            end
            if (load) begin
                cur_reg  <= q_item;
                step_reg <= '0;
                hk_reg   <= '0;
                ri_reg   <= q_item.first_col ? 2'd0 : 2'd1;
                state_reg <= (q_item.op == OP_START) ? B_START : B_RAW;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_end_reg;

    `PNGSE_ASSERT_IMPL(a_end_is_last, aclk, aresetn, out_valid_reg && out_end_reg, out_last_reg)
    `PNGSE_ASSERT_IMPL(a_raw_ready, aclk, aresetn, fire && state_reg == B_START && step_reg == ST_LAST, zl_res.done)
    `PNGSE_ASSERT_NEVER(a_adler_range, aclk, aresetn, alo_reg >= 16'd65521 || ahi_reg >= 16'd65521)
    `PNGSE_ASSERT_NEVER(a_hdr_count, aclk, aresetn, hk_reg > HK_DONE)

endmodule

/* design/png_stored_stream_encoder_core.sv */
// Top level of the PNG stored-stream encoder: APB frame size registers,
// front, queue, size unit and back part. Depends on pngse_pkg and submodules.
//
// One result byte leaves per clock while m_tready is high and the back part has a
// byte ready (a queued item, and the IDAT length once a start item needs it).
// Bytes per item: a start item 43, a pixel 3, plus 1 at the start of a row and
// 5 before each stored block, and the last pixel a further 20. The byte sequencer
// in the back part and its single result register set this pace; the queue lets
// the next items in meanwhile. The IDAT length comes from one multiply and a
// reciprocal multiply for the block count, ready well before the start item's
// 34th byte needs it.
module png_stored_stream_encoder_core #(
    parameter int BLOCK_BYTES = pngse_pkg::DEF_BLOCK_BYTES,
    parameter int MAX_SIDE    = pngse_pkg::DEF_MAX_SIDE
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red, green, blue
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte
    output logic        m_tlast,   // last_of_run
    output logic        m_tuser,   // file_end
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pngse_pkg::*;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    logic [CFG_W-1:0] fw_reg;
    logic [CFG_W-1:0] fh_reg;
    logic             cfg_wr;
    logic             q_full;
    logic             q_push;
    item_t            push_item;
    logic             q_pop;
    logic             q_valid;
    item_t            head;
    logic             zl_start;
    zl_res_t          zl_res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_HEIGHT) ? 32'(fh_reg) : 32'(fw_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg <= CFG_W'(1);
            fh_reg <= CFG_W'(1);
        end else if (cfg_wr) begin
            if (paddr[2] == REG_WIDTH) fw_reg <= pwdata[CFG_W-1:0];
            else fh_reg <= pwdata[CFG_W-1:0];
        end
    end

    pngse_front #(.MAX_SIDE(MAX_SIDE)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg_width  (fw_reg),
        .cfg_height (fh_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (push_item)
    );

    pngse_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (head)
    );

    pngse_zlen #(.BLOCK_BYTES(BLOCK_BYTES)) u_zlen (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (zl_start),
        .width   (head.width),
        .height  (head.height),
        .res     (zl_res)
    );

    pngse_back #(.BLOCK_BYTES(BLOCK_BYTES)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (head),
        .q_pop    (q_pop),
        .zl_start (zl_start),
        .zl_res   (zl_res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

/* tb/tb_png_stored_stream_encoder_core.sv */
// Self-checking testbench for png_stored_stream_encoder_core: drives start and pixel
// transactions, predicts every PNG stream byte and compares the m_ side byte by byte.
// Depends on pngse_pkg and the encoder RTL.
module tb_png_stored_stream_encoder_core;
    import pngse_pkg::*;

    localparam int BLOCK_LEN = 65535;
    localparam int SIDE_MAX = 8192;
    localparam logic [2:0] ADDR_WIDTH = 3'd0;
    localparam logic [2:0] ADDR_HEIGHT = 3'd4;
    localparam longint CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 385;

    typedef struct packed {
        logic [7:0] data;
        logic       last_of_run;
        logic       file_end;
    } out_byte_t;

    typedef struct {
        op_t        op;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    png_stored_stream_encoder_core uut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // encoder model state
    logic [13:0] reg_width = 14'd1, reg_height = 14'd1;
    logic [31:0] crc;
    logic [15:0] ad_lo, ad_hi;
    int unsigned col, rw, blk_fill, raw_left, lat_w, lat_h;
    bit          in_frame;

    out_byte_t   stream_q[$];
    out_byte_t   step_q[$];
    int          errors = 0;
    longint      cycles = 0;
    bit          long_hold = 1'b0;
    int          rx_mode = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, exp, cycles);
        errors++;
    endtask

    function automatic logic [31:0] crc_step(input logic [31:0] c0, input logic [7:0] b);
        logic [31:0] c;
        c = c0 ^ {24'd0, b};
        for (int k = 0; k < 8; k++) c = c[0] ? (32'hEDB88320 ^ (c >> 1)) : (c >> 1);
        return c;
    endfunction

    task automatic emit(input logic [7:0] b, input bit in_crc);
        out_byte_t o;
        if (in_crc) crc = crc_step(crc, b);
        o.data = b;
        o.last_of_run = 1'b0;
        o.file_end = 1'b0;
        step_q = {step_q, o};
    endtask

    task automatic emit_word(input logic [31:0] w, input bit in_crc);
        for (int i = 3; i >= 0; i--) emit(w[8*i +: 8], in_crc);
    endtask

    task automatic emit_tag(input logic [31:0] tag);
        crc = 32'hFFFFFFFF;
        emit_word(tag, 1'b1);
    endtask

    task automatic emit_raw(input logic [7:0] v);
        int unsigned blen;
        if (blk_fill == 0) begin
            blen = raw_left < BLOCK_LEN ? raw_left : BLOCK_LEN;
            emit({7'd0, raw_left <= BLOCK_LEN}, 1'b1);
            emit(blen[7:0], 1'b1);
            emit(blen[15:8], 1'b1);
            emit(~blen[7:0], 1'b1);
            emit(~blen[15:8], 1'b1);
        end
        emit(v, 1'b1);
        ad_lo = 16'((32'(ad_lo) + 32'(v)) % 65521);
        ad_hi = 16'((32'(ad_hi) + 32'(ad_lo)) % 65521);
        blk_fill++;
        if (blk_fill >= BLOCK_LEN) blk_fill = 0;
        if (raw_left > 0) raw_left--;
    endtask

    function automatic int unsigned clamp_side(input logic [13:0] v);
        if (v == 0) return 1;
        if (v > SIDE_MAX) return SIDE_MAX;
        return {18'd0, v};
    endfunction

    task automatic encode_item(input op_t op, input logic [7:0] r, input logic [7:0] g,
                               input logic [7:0] b);
        longint unsigned raw, nblk, zlen;
        logic [7:0] sig[8] = '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
        step_q.delete();
        if (op == OP_START) begin
            lat_w = clamp_side(reg_width);
            lat_h = clamp_side(reg_height);
            raw = longint'(lat_h) * (1 + 3 * longint'(lat_w));
            nblk = (raw + BLOCK_LEN - 1) / BLOCK_LEN;
            zlen = 6 + raw + 5 * nblk;
            foreach (sig[i]) emit(sig[i], 1'b0);
            emit_word(32'd13, 1'b0);
            emit_tag(TAG_IHDR);
            emit_word(lat_w, 1'b1);
            emit_word(lat_h, 1'b1);
            emit(8'd8, 1'b1);
            emit(8'd2, 1'b1);
            emit(8'd0, 1'b1);
            emit(8'd0, 1'b1);
            emit(8'd0, 1'b1);
            emit_word(~crc, 1'b0);
            emit_word(zlen[31:0], 1'b0);
            emit_tag(TAG_IDAT);
            emit(8'h78, 1'b1);
            emit(8'h01, 1'b1);
            ad_lo = 16'd1;
            ad_hi = 16'd0;
            col = 0;
            rw = 0;
            blk_fill = 0;
            raw_left = raw[31:0];
            in_frame = 1'b1;
        end else if (in_frame) begin
            if (col == 0) emit_raw(8'd0);
            emit_raw(r);
            emit_raw(g);
            emit_raw(b);
            col++;
            if (col >= lat_w) begin
                col = 0;
                rw++;
                if (rw >= lat_h) begin
                    rw = 0;
                    emit_word({ad_hi, ad_lo}, 1'b1);
                    emit_word(~crc, 1'b0);
                    emit_word(32'd0, 1'b0);
                    emit_tag(TAG_IEND);
                    emit_word(~crc, 1'b0);
                    step_q[$].file_end = 1'b1;
                    in_frame = 1'b0;
                    ad_lo = 16'd1;
                    ad_hi = 16'd0;
                    blk_fill = 0;
                    raw_left = 0;
                end
            end
        end
        if (step_q.size() > 0) step_q[$].last_of_run = 1'b1;
        stream_q = {stream_q, step_q};
    endtask

    // ---- result side
    always @(posedge aclk) begin
        out_byte_t e;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_png_stored_stream_encoder_core NOT OK");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (stream_q.size() == 0) begin
                report("unexpected byte", 32'(m_tdata), 32'd0);
            end else begin
                e = stream_q.pop_front();
                if (m_tdata !== e.data) report("out_byte", 32'(m_tdata), 32'(e.data));
                if (m_tlast !== e.last_of_run)
                    report("last_of_run", 32'(m_tlast), 32'(e.last_of_run));
                if (m_tuser !== e.file_end) report("file_end", 32'(m_tuser), 32'(e.file_end));
            end
        end
        if (long_hold) begin
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= (cycles % 7 < 3);
            endcase
        end
        if (cycles % 500 == 0) rx_mode <= $urandom_range(0, 2);
    end

    // ---- stimulus side
    int burst_left = 0;
    int gap_left = 0;
    int sent = 0;
    bit tv_on = 1'b0;

    task automatic send(input op_t op, input logic [7:0] r, input logic [7:0] g,
                        input logic [7:0] b);
        if (gap_left > 0) begin
            repeat (gap_left) @(posedge aclk);
            gap_left = 0;
        end
        if (burst_left == 0) burst_left = $urandom_range(1, 12);
        s_tvalid <= 1'b1;
        tv_on = 1'b1;
        s_tuser <= op;
        s_tdata <= {b, g, r};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        encode_item(op, r, g, b);
        sent++;
        burst_left--;
        if (burst_left == 0) begin
            gap_left = $urandom_range(0, 5);
            if (gap_left > 0) begin
                s_tvalid <= 1'b0;
                tv_on = 1'b0;
            end
        end
    endtask

    task automatic drain();
        if (tv_on) begin
            s_tvalid <= 1'b0;
            tv_on = 1'b0;
        end
        burst_left = 0;
        while (stream_q.size() > 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_WIDTH) reg_width = val[13:0];
        else reg_height = val[13:0];
        @(posedge aclk);
    endtask

    task automatic set_size(input logic [31:0] w, input logic [31:0] h);
        drain();
        write_reg(ADDR_WIDTH, w);
        write_reg(ADDR_HEIGHT, h);
    endtask

    task automatic random_frame(input int npix_extra);
        int n;
        n = int'(clamp_side(reg_width) * clamp_side(reg_height));
        send(OP_START, 8'($urandom), 8'($urandom), 8'($urandom));
        for (int i = 0; i < n + npix_extra; i++)
            send(OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    stim_row_t dir_rows[] = '{
        '{OP_PIXEL, 8'h12, 8'h34, 8'h56},
        '{OP_START, 8'h00, 8'h00, 8'h00},
        '{OP_PIXEL, 8'h00, 8'h00, 8'h00},
        '{OP_PIXEL, 8'hFF, 8'hFF, 8'hFF},
        '{OP_START, 8'hAA, 8'h55, 8'hAA},
        '{OP_PIXEL, 8'hFF, 8'hFF, 8'hFF},
        '{OP_PIXEL, 8'h55, 8'hAA, 8'h55}
    };

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // reset size 1x1; idle pixels ignored; two complete 1x1 frames
        foreach (dir_rows[i]) send(dir_rows[i].op, dir_rows[i].r, dir_rows[i].g, dir_rows[i].b);
        // the 1x1 frame's last byte must be the IEND CRC tail with file_end
        drain();
        set_size(32'd0, 32'd0);
        random_frame(0);
        set_size(32'h3FFF, 32'd1);
        send(OP_START, 8'd0, 8'd0, 8'd0);
        for (int i = 0; i < 5; i++) send(OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
        set_size(32'd3, 32'd2);
        random_frame(0);
        // long receiver hold-off while the sender keeps offering
        drain();
        long_hold = 1'b1;
        fork
            begin
                repeat (300) @(posedge aclk);
                long_hold = 1'b0;
            end
            random_frame(0);
        join
        set_size(32'd2, 32'd2);
        send(OP_START, 8'd0, 8'd0, 8'd0);
        send(OP_PIXEL, 8'd1, 8'd2, 8'd3);
        send(OP_START, 8'd0, 8'd0, 8'd0);
        while (sent < ITEM_TARGET) begin
            int w, h;
            w = $urandom_range(1, 6);
            h = $urandom_range(1, 5);
            set_size(w, h);
            repeat ($urandom_range(1, 3)) random_frame($urandom_range(0, 1));
        end
        // start a frame that spans two stored blocks, then abandon it
        set_size(SIDE_MAX, 32'd3);
        send(OP_START, 8'd0, 8'd0, 8'd0);
        for (int i = 0; i < 4; i++) send(OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
        drain();
        repeat (60) @(posedge aclk);
        if (errors == 0) begin
            $display("tb_png_stored_stream_encoder_core OK");
        end else begin
            $display("tb_png_stored_stream_encoder_core NOT OK");
        end
        $finish;
    end
endmodule

/* files.f */
+incdir+design
design/pngse_pkg.sv
design/pngse_front.sv
design/pngse_queue.sv
design/pngse_zlen.sv
design/pngse_back.sv
design/png_stored_stream_encoder_core.sv
tb/tb_png_stored_stream_encoder_core.sv
